// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the verification checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is asserted
`define BTOK_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tokenizer check failed: same-cycle implication");

// Next-cycle implication, masked while reset is asserted
`define BTOK_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tokenizer check failed: next-cycle implication");

// Next-cycle implication that also holds across reset
`define BTOK_ASSERT_NXT_ALWAYS(name, clk, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("tokenizer check failed: next-cycle implication");

`endif

// ===== src/btok_pkg.sv =====
// ---------------------------------------------------------------------------
// btok_pkg
// Types, constants and helper functions of the source tokenizer.
// ---------------------------------------------------------------------------
package btok_pkg;

  localparam int NUMBER_BITS   = 32;
  localparam int LINE_BITS     = 20;
  localparam int CHAR_BITS     = 8;
  localparam int KIND_BITS     = 5;
  localparam int MAX_RESULTS   = 4;
  localparam int CNT_BITS      = $clog2(MAX_RESULTS + 1);
  localparam int RD_BITS       = $clog2(MAX_RESULTS);
  localparam int KW_CHARS      = 6;
  localparam int KW_BITS       = KW_CHARS * CHAR_BITS;
  localparam int LEN_BITS      = 3;
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [LINE_BITS-1:0] FIRST_LINE_RESET = LINE_BITS'(1);
  localparam logic [LINE_BITS-1:0] LINE_MAX         = '1;
  localparam logic [LEN_BITS-1:0]  LEN_MAX          = '1;

  // Keyword text, first byte in the low bits
  localparam logic [KW_BITS-1:0] KW_EXTRN  = KW_BITS'(48'h00_6E_72_74_78_65);
  localparam logic [KW_BITS-1:0] KW_RETURN = KW_BITS'(48'h6E_72_75_74_65_72);
  localparam logic [KW_BITS-1:0] KW_IF     = KW_BITS'(48'h00_00_00_00_66_69);
  localparam logic [KW_BITS-1:0] KW_ELSE   = KW_BITS'(48'h00_00_65_73_6C_65);

  localparam logic [CHAR_BITS-1:0] CH_QUOTE   = 8'h22;
  localparam logic [CHAR_BITS-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [CHAR_BITS-1:0] CH_ZERO    = 8'h30;

  // Configuration register index
  typedef enum logic [0:0] {
    REG_FIRST_LINE = 1'b0
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_NUM   = 2'd1,
    MODE_IDENT = 2'd2,
    MODE_STR   = 2'd3
  } scan_mode_t;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_TEXT   = 5'd0,
    KIND_NUMBER = 5'd1,
    KIND_IDENT  = 5'd2,
    KIND_STRING = 5'd3,
    KIND_EXTRN  = 5'd4,
    KIND_RETURN = 5'd5,
    KIND_IF     = 5'd6,
    KIND_ELSE   = 5'd7,
    KIND_LPAREN = 5'd8,
    KIND_RPAREN = 5'd9,
    KIND_LBRACE = 5'd10,
    KIND_RBRACE = 5'd11,
    KIND_LBRACK = 5'd12,
    KIND_RBRACK = 5'd13,
    KIND_COMMA  = 5'd14,
    KIND_SEMI   = 5'd15,
    KIND_PLUS   = 5'd16,
    KIND_MINUS  = 5'd17,
    KIND_STAR   = 5'd18,
    KIND_SLASH  = 5'd19,
    KIND_END    = 5'd20
  } token_kind_t;

  typedef struct packed {
    scan_mode_t               mode;
    logic [NUMBER_BITS-1:0]   acc;
    logic [LINE_BITS-1:0]     line;
    logic [LINE_BITS-1:0]     start;
    logic [KW_BITS-1:0]       kbuf;
    logic [LEN_BITS-1:0]      len;
  } scan_state_t;

  typedef struct packed {
    token_kind_t              kind;
    logic [NUMBER_BITS-1:0]   num;
    logic [CHAR_BITS-1:0]     text;
    logic [LINE_BITS-1:0]     line;
  } result_t;

  typedef struct packed {
    logic [CNT_BITS-1:0]             count;
    result_t [MAX_RESULTS-1:0]       res;
  } result_set_t;

  function automatic logic is_digit(input logic [CHAR_BITS-1:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_letter(input logic [CHAR_BITS-1:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_punct(input logic [CHAR_BITS-1:0] c);
    case (c)
      "(", ")", "{", "}", "[", "]", ",", ";", "+", "-", "*", "/": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic token_kind_t punct_kind(input logic [CHAR_BITS-1:0] c);
    case (c)
      "(":     return KIND_LPAREN;
      ")":     return KIND_RPAREN;
      "{":     return KIND_LBRACE;
      "}":     return KIND_RBRACE;
      "[":     return KIND_LBRACK;
      "]":     return KIND_RBRACK;
      ",":     return KIND_COMMA;
      ";":     return KIND_SEMI;
      "+":     return KIND_PLUS;
      "-":     return KIND_MINUS;
      "*":     return KIND_STAR;
      "/":     return KIND_SLASH;
      default: return KIND_TEXT;
    endcase
  endfunction

  // Identifier or one of the four keywords
  function automatic token_kind_t kw_kind(input logic [KW_BITS-1:0] kbuf,
                                          input logic [LEN_BITS-1:0] len);
    if (len == LEN_BITS'(5) && kbuf == KW_EXTRN)       return KIND_EXTRN;
    else if (len == LEN_BITS'(6) && kbuf == KW_RETURN) return KIND_RETURN;
    else if (len == LEN_BITS'(2) && kbuf == KW_IF)     return KIND_IF;
    else if (len == LEN_BITS'(4) && kbuf == KW_ELSE)   return KIND_ELSE;
    else                                               return KIND_IDENT;
  endfunction

  function automatic result_t mk_result(input token_kind_t kind,
                                        input logic [NUMBER_BITS-1:0] num,
                                        input logic [CHAR_BITS-1:0] text,
                                        input logic [LINE_BITS-1:0] line);
    result_t r;
    r.kind = kind;
    r.num  = num;
    r.text = text;
    r.line = line;
    return r;
  endfunction

  // State at reset and after the last byte of a source
  function automatic scan_state_t scan_reset(input logic [LINE_BITS-1:0] first_line);
    scan_state_t s;
    s.mode  = MODE_IDLE;
    s.acc   = '0;
    s.line  = first_line;
    s.start = '0;
    s.kbuf  = '0;
    s.len   = '0;
    return s;
  endfunction

endpackage

// ===== src/btok_in_if.sv =====
// ---------------------------------------------------------------------------
// btok_in_if
// Character channel: one source byte per word, with a last-byte flag.
// ---------------------------------------------------------------------------
interface btok_in_if import btok_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CHAR_BITS-1:0] character;
  logic                 final_char;

  modport source (output valid, character, final_char, input ready);
  modport sink   (input valid, character, final_char, output ready);
endinterface

// ===== src/btok_out_if.sv =====
// ---------------------------------------------------------------------------
// btok_out_if
// Token channel: one token or echoed character per word.
// ---------------------------------------------------------------------------
interface btok_out_if import btok_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [KIND_BITS-1:0]   token_kind;
  logic [NUMBER_BITS-1:0] number_value;
  logic [CHAR_BITS-1:0]   text_char;
  logic [LINE_BITS-1:0]   line_number;
  logic                   last_result;

  modport source (output valid, token_kind, number_value, text_char, line_number,
                  last_result, input ready);
  modport sink   (input valid, token_kind, number_value, text_char, line_number,
                  last_result, output ready);
endinterface

// ===== src/btok_scan.sv =====
// ---------------------------------------------------------------------------
// btok_scan
// Scanner step: from one byte and the scan state, the next state and the
// list of up to four words that the byte produces.
// ---------------------------------------------------------------------------
module btok_scan import btok_pkg::*; (
  input  logic [CHAR_BITS-1:0] character,
  input  logic                 final_char,
  input  scan_state_t          st,
  input  logic [LINE_BITS-1:0] first_line,
  output scan_state_t          st_nxt,
  output result_set_t          rset
);

  always_comb begin : scan_step
    scan_state_t               s;
    result_t [MAX_RESULTS-1:0] res;
    logic [CNT_BITS-1:0]       n;
    logic                      idle;
    logic [CHAR_BITS-1:0]      c;

    s    = st;
    res  = '0;
    n    = '0;
    idle = 1'b0;
    c    = character;

    // Continue or close the open token
    case (s.mode)
      MODE_NUM: begin
        if (is_digit(c)) begin
          s.acc = (s.acc << 3) + (s.acc << 1) + NUMBER_BITS'(c - CH_ZERO);
        end else begin
          res[n[RD_BITS-1:0]] = mk_result(KIND_NUMBER, s.acc, '0, s.start);
          n      = n + CNT_BITS'(1);
          s.mode = MODE_IDLE;
          s.acc  = '0;
          s.kbuf = '0;
          s.len  = '0;
          idle   = 1'b1;
        end
      end
      MODE_IDENT: begin
        if (is_letter(c) || is_digit(c)) begin
          if (s.len < LEN_BITS'(KW_CHARS)) s.kbuf[{s.len, 3'b000} +: CHAR_BITS] = c;
          if (s.len != LEN_MAX) s.len = s.len + LEN_BITS'(1);
          res[n[RD_BITS-1:0]] = mk_result(KIND_TEXT, '0, c, s.start);
          n = n + CNT_BITS'(1);
        end else begin
          res[n[RD_BITS-1:0]] = mk_result(kw_kind(s.kbuf, s.len), '0, '0, s.start);
          n      = n + CNT_BITS'(1);
          s.mode = MODE_IDLE;
          s.acc  = '0;
          s.kbuf = '0;
          s.len  = '0;
          idle   = 1'b1;
        end
      end
      MODE_STR: begin
        if (c == CH_QUOTE) begin
          res[n[RD_BITS-1:0]] = mk_result(KIND_STRING, '0, '0, s.start);
          n      = n + CNT_BITS'(1);
          s.mode = MODE_IDLE;
          s.acc  = '0;
          s.kbuf = '0;
          s.len  = '0;
        end else begin
          res[n[RD_BITS-1:0]] = mk_result(KIND_TEXT, '0, c, s.start);
          n = n + CNT_BITS'(1);
        end
      end
      default: idle = 1'b1;
    endcase

    // Handle the byte from idle: open a token, count a line or emit punctuation
    if (idle) begin
      if (is_digit(c)) begin
        s.mode  = MODE_NUM;
        s.start = s.line;
        s.acc   = NUMBER_BITS'(c - CH_ZERO);
      end else if (is_letter(c)) begin
        s.mode  = MODE_IDENT;
        s.start = s.line;
        s.kbuf  = KW_BITS'(c);
        s.len   = LEN_BITS'(1);
        res[n[RD_BITS-1:0]] = mk_result(KIND_TEXT, '0, c, s.start);
        n = n + CNT_BITS'(1);
      end else if (c == CH_QUOTE) begin
        s.mode  = MODE_STR;
        s.start = s.line;
      end else if (c == CH_NEWLINE) begin
        if (s.line != LINE_MAX) s.line = s.line + LINE_BITS'(1);
      end else if (is_punct(c)) begin
        res[n[RD_BITS-1:0]] = mk_result(punct_kind(c), '0, '0, s.line);
        n = n + CNT_BITS'(1);
      end
    end

    // Last byte: flush the open token, emit end, start a new source
    if (final_char) begin
      case (s.mode)
        MODE_NUM: begin
          res[n[RD_BITS-1:0]] = mk_result(KIND_NUMBER, s.acc, '0, s.start);
          n = n + CNT_BITS'(1);
        end
        MODE_IDENT: begin
          res[n[RD_BITS-1:0]] = mk_result(kw_kind(s.kbuf, s.len), '0, '0, s.start);
          n = n + CNT_BITS'(1);
        end
        MODE_STR: begin
          res[n[RD_BITS-1:0]] = mk_result(KIND_STRING, '0, '0, s.start);
          n = n + CNT_BITS'(1);
        end
        default: ;
      endcase
      res[n[RD_BITS-1:0]] = mk_result(KIND_END, '0, '0, s.line);
      n = n + CNT_BITS'(1);
      s = scan_reset(first_line);
    end

    st_nxt     = s;
    rset.count = n;
    rset.res   = res;
  end

endmodule

// ===== src/btok_obuf.sv =====
// ---------------------------------------------------------------------------
// btok_obuf
// Result buffer: holds the words of one byte and hands them out in order.
// ---------------------------------------------------------------------------
module btok_obuf import btok_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  result_set_t       rset,
  output logic              free,
  btok_out_if.source        out_chan
);

  result_t [MAX_RESULTS-1:0] res_r;
  logic [CNT_BITS-1:0]       cnt_r;
  logic [RD_BITS-1:0]        rd_r;
  logic                      last;
  logic                      pop;
  result_t                   head;

  assign head = res_r[rd_r];
  assign last = ({1'b0, rd_r} == (cnt_r - CNT_BITS'(1)));
  assign pop  = out_chan.valid && out_chan.ready;
  // Empty now, or the last word leaves at this edge
  assign free = (cnt_r == '0) || (pop && last);

  // Drive the head word
  assign out_chan.valid        = (cnt_r != '0);
  assign out_chan.token_kind   = head.kind;
  assign out_chan.number_value = head.num;
  assign out_chan.text_char    = head.text;
  assign out_chan.line_number  = head.line;
  assign out_chan.last_result  = last;

  // Load a new set, advance on each taken word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= '0;
    end else if (load) begin
      cnt_r <= rset.count;
      rd_r  <= '0;
    end else if (pop) begin
      if (last) begin
        cnt_r <= '0;
        rd_r  <= '0;
      end else begin
        rd_r <= rd_r + RD_BITS'(1);
      end
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (load) res_r <= rset.res;
  end

endmodule

// ===== src/b_language_tokenizer_unit.sv =====
// ---------------------------------------------------------------------------
// b_language_tokenizer_unit
// Streaming tokenizer for a small B-like language: bytes in, tokens out.
// ---------------------------------------------------------------------------
//  channel   dir  word                                   handshake
//  in_chan   in   character, final_char                  valid/ready
//  out_chan  out  token_kind, number_value, text_char,   valid/ready
//                 line_number, last_result
//  cfg_*     in   first_line at byte address 0           APB, pready high
//
//  A byte is registered, scanned in the next cycle and its words loaded into
//  the result buffer; it sends one word per cycle while out_chan is ready.
//  Bytes with at most one word then sustain one byte per cycle; a byte with
//  more words holds the next one until all are sent, set by the single output
//  port. Synchronous active-low reset; no clearing pass. Stalls on out_chan
//  back up through the buffer into the input register and in_chan.ready.
// ---------------------------------------------------------------------------
module b_language_tokenizer_unit import btok_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  btok_in_if.sink                  in_chan,
  btok_out_if.source               out_chan,
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [CFG_DATA_BITS-1:0] cfg_pwdata,
  output logic [CFG_DATA_BITS-1:0] cfg_prdata,
  output logic                     cfg_pready
);

  logic                 in_v_r;
  logic [CHAR_BITS-1:0] in_char_r;
  logic                 in_fin_r;
  logic [LINE_BITS-1:0] first_line_r;
  scan_state_t          st_r;
  scan_state_t          st_nxt;
  result_set_t          rset;
  logic                 buf_free;
  logic                 load;
  logic                 cfg_wr;
  cfg_reg_t             cfg_reg;

  // Configuration register
  assign cfg_pready = 1'b1;
  assign cfg_reg    = cfg_reg_t'(cfg_paddr[2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_line_r <= FIRST_LINE_RESET;
    end else if (cfg_wr && cfg_reg == REG_FIRST_LINE) begin
      first_line_r <= cfg_pwdata[LINE_BITS-1:0];
    end
  end

  always_comb begin
    case (cfg_reg)
      REG_FIRST_LINE: cfg_prdata = CFG_DATA_BITS'(first_line_r);
      default:        cfg_prdata = '0;
    endcase
  end

  // Input register: take a byte when empty or moving on
  assign load          = in_v_r && buf_free;
  assign in_chan.ready = !in_v_r || load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_v_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      in_char_r <= in_chan.character;
      in_fin_r  <= in_chan.final_char;
    end
  end

  // Scan state: advance when the byte's words enter the buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= scan_reset(FIRST_LINE_RESET);
    end else if (load) begin
      st_r <= st_nxt;
    end
  end

  btok_scan u_scan (
    .character  (in_char_r),
    .final_char (in_fin_r),
    .st         (st_r),
    .first_line (first_line_r),
    .st_nxt     (st_nxt),
    .rset       (rset)
  );

  btok_obuf u_obuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (load),
    .rset     (rset),
    .free     (buf_free),
    .out_chan (out_chan)
  );

endmodule

// ===== src/btok_checker.sv =====
// ---------------------------------------------------------------------------
// btok_checker
// Port-level checks on the token channel of the tokenizer.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module btok_checker import btok_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [KIND_BITS-1:0]   out_kind,
  input logic [NUMBER_BITS-1:0] out_num,
  input logic [CHAR_BITS-1:0]   out_text,
  input logic [LINE_BITS-1:0]   out_line,
  input logic                   out_last
);

  logic                                              stalled;
  logic                                              is_end;
  logic                                              is_text;
  logic [KIND_BITS+NUMBER_BITS+CHAR_BITS+LINE_BITS:0] out_word;

  assign stalled  = out_valid && !out_ready;
  assign is_end   = out_valid && (out_kind == KIND_END);
  assign is_text  = (out_kind == KIND_TEXT);
  assign out_word = {out_kind, out_num, out_text, out_line, out_last};

  // A stalled word holds
  `BTOK_ASSERT_NXT(a_hold, clk, rst_n, stalled, out_valid && $stable(out_word))

  // Nothing pending right after reset
  `BTOK_ASSERT_NXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid)

  // The end token closes the words of its byte
  `BTOK_ASSERT_IMP(a_end_last, clk, rst_n, is_end, out_last)

  // Only echoed characters carry a character
  `BTOK_ASSERT_IMP(a_text_zero, clk, rst_n, out_valid && !is_text, out_text == '0)

endmodule

bind b_language_tokenizer_unit btok_checker u_btok_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_kind  (out_chan.token_kind),
  .out_num   (out_chan.number_value),
  .out_text  (out_chan.text_char),
  .out_line  (out_chan.line_number),
  .out_last  (out_chan.last_result)
);

// ===== tb/tokenizer_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tokenizer_checker
// Watches the character and token channels and the configuration port. It
// runs its own scanner on each accepted character, queues the token words
// that the character should cause, and compares every word that leaves the
// block against the oldest queued word.
// ---------------------------------------------------------------------------
module tokenizer_checker import btok_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  btok_in_if                       in_mon,
  btok_out_if                      out_mon,
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic                     cfg_pready,
  input  logic [CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [CFG_DATA_BITS-1:0] cfg_pwdata,
  output int unsigned              mismatch_count,
  output int unsigned              words_pending
);

  localparam logic [CFG_ADDR_BITS-1:0] FIRST_LINE_ADDR = {REG_FIRST_LINE, 2'b00};
  localparam int unsigned              REPORT_LIMIT    = 10;

  typedef struct packed {
    token_kind_t            kind;
    logic [NUMBER_BITS-1:0] num;
    logic [CHAR_BITS-1:0]   text;
    logic [LINE_BITS-1:0]   line;
    logic                   last;
  } token_word_t;

  token_word_t            token_words[$];

  // Scanner state and register copy
  logic [LINE_BITS-1:0]   first_line_reg = FIRST_LINE_RESET;
  scan_mode_t             mode           = MODE_IDLE;
  logic [NUMBER_BITS-1:0] number_acc     = '0;
  logic [LINE_BITS-1:0]   line_ctr       = FIRST_LINE_RESET;
  logic [LINE_BITS-1:0]   start_line     = '0;
  logic [KW_BITS-1:0]     kw_text        = '0;
  logic [LEN_BITS-1:0]    ident_len      = '0;
  int unsigned            mismatches     = 0;

  function automatic bit digit_char(input logic [CHAR_BITS-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_ZERO + 8'd9);
  endfunction

  // Fold case, then one range test covers both alphabets
  function automatic bit letter_char(input logic [CHAR_BITS-1:0] c);
    logic [CHAR_BITS-1:0] folded;
    folded = c | 8'h20;
    return (folded >= "a") && (folded <= "z");
  endfunction

  function automatic bit punct_lookup(input logic [CHAR_BITS-1:0] c,
                                      output token_kind_t kind);
    bit hit;
    hit = 1'b1;
    kind = KIND_TEXT;
    case (c)
      "(": kind = KIND_LPAREN;
      ")": kind = KIND_RPAREN;
      "{": kind = KIND_LBRACE;
      "}": kind = KIND_RBRACE;
      "[": kind = KIND_LBRACK;
      "]": kind = KIND_RBRACK;
      ",": kind = KIND_COMMA;
      ";": kind = KIND_SEMI;
      "+": kind = KIND_PLUS;
      "-": kind = KIND_MINUS;
      "*": kind = KIND_STAR;
      "/": kind = KIND_SLASH;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  // Length must match too, so a long name sharing six bytes stays a name
  function automatic token_kind_t word_kind();
    if (ident_len == 3'd5 && kw_text == KW_EXTRN) return KIND_EXTRN;
    if (ident_len == 3'd6 && kw_text == KW_RETURN) return KIND_RETURN;
    if (ident_len == 3'd2 && kw_text == KW_IF) return KIND_IF;
    if (ident_len == 3'd4 && kw_text == KW_ELSE) return KIND_ELSE;
    return KIND_IDENT;
  endfunction

  task automatic queue_word(input token_kind_t kind, input logic [NUMBER_BITS-1:0] num,
                            input logic [CHAR_BITS-1:0] text,
                            input logic [LINE_BITS-1:0] line);
    token_word_t w;
    w.kind = kind;
    w.num  = num;
    w.text = text;
    w.line = line;
    w.last = 1'b0;
    token_words = {token_words, w};
  endtask

  task automatic drop_token();
    mode       = MODE_IDLE;
    number_acc = '0;
    kw_text    = '0;
    ident_len  = '0;
  endtask

  task automatic close_word();
    queue_word(word_kind(), '0, '0, start_line);
    drop_token();
  endtask

  // Keep the first six bytes, count up to seven, echo the byte
  task automatic grow_word(input logic [CHAR_BITS-1:0] c);
    if (ident_len < 3'd6) kw_text[8*ident_len +: 8] = c;
    if (ident_len != LEN_MAX) ident_len++;
    queue_word(KIND_TEXT, '0, c, start_line);
  endtask

  task automatic scan_idle(input logic [CHAR_BITS-1:0] c);
    token_kind_t pk;
    if (digit_char(c)) begin
      mode       = MODE_NUM;
      start_line = line_ctr;
      number_acc = NUMBER_BITS'(c - CH_ZERO);
    end else if (letter_char(c)) begin
      mode       = MODE_IDENT;
      start_line = line_ctr;
      kw_text    = '0;
      ident_len  = '0;
      grow_word(c);
    end else if (c == CH_QUOTE) begin
      mode       = MODE_STR;
      start_line = line_ctr;
    end else if (c == CH_NEWLINE) begin
      if (line_ctr != LINE_MAX) line_ctr++;
    end else if (punct_lookup(c, pk)) begin
      queue_word(pk, '0, '0, line_ctr);
    end
  endtask

  // Advance the scanner by one character and queue the words it causes
  task automatic scan_byte(input logic [CHAR_BITS-1:0] c, input logic fin);
    int unsigned first_new;
    first_new = token_words.size();
    case (mode)
      MODE_NUM: begin
        if (digit_char(c)) begin
          number_acc = number_acc * NUMBER_BITS'(10) + NUMBER_BITS'(c - CH_ZERO);
        end else begin
          queue_word(KIND_NUMBER, number_acc, '0, start_line);
          drop_token();
          scan_idle(c);
        end
      end
      MODE_IDENT: begin
        if (letter_char(c) || digit_char(c)) begin
          grow_word(c);
        end else begin
          close_word();
          scan_idle(c);
        end
      end
      MODE_STR: begin
        if (c == CH_QUOTE) begin
          queue_word(KIND_STRING, '0, '0, start_line);
          drop_token();
        end else begin
          queue_word(KIND_TEXT, '0, c, start_line);
        end
      end
      default: scan_idle(c);
    endcase
    // Flush an open token, emit end, start a fresh source
    if (fin) begin
      case (mode)
        MODE_NUM:   queue_word(KIND_NUMBER, number_acc, '0, start_line);
        MODE_IDENT: close_word();
        MODE_STR:   queue_word(KIND_STRING, '0, '0, start_line);
        default: ;
      endcase
      queue_word(KIND_END, '0, '0, line_ctr);
      drop_token();
      line_ctr   = first_line_reg;
      start_line = '0;
    end
    // Flag the last word of this character
    if (token_words.size() > first_new)
      token_words[token_words.size() - 1].last = 1'b1;
  endtask

  // Compare outgoing words first, then predict from the incoming character
  always @(posedge clk) begin
    token_word_t want;
    if (!rst_n) begin
      first_line_reg = FIRST_LINE_RESET;
      drop_token();
      line_ctr       = FIRST_LINE_RESET;
      start_line     = '0;
      token_words.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (token_words.size() == 0) begin
          if (mismatches < REPORT_LIMIT)
            $display("unexpected token word: kind %0d number %h text %h line %0d last %b",
                     out_mon.token_kind, out_mon.number_value, out_mon.text_char,
                     out_mon.line_number, out_mon.last_result);
          mismatches++;
        end else begin
          want = token_words.pop_front();
          if (out_mon.token_kind !== want.kind || out_mon.number_value !== want.num ||
              out_mon.text_char !== want.text || out_mon.line_number !== want.line ||
              out_mon.last_result !== want.last) begin
            if (mismatches < REPORT_LIMIT) begin
              $display("token word mismatch, expected: kind %0d number %h text %h line %0d last %b",
                       want.kind, want.num, want.text, want.line, want.last);
              $display("                       actual: kind %0d number %h text %h line %0d last %b",
                       out_mon.token_kind, out_mon.number_value, out_mon.text_char,
                       out_mon.line_number, out_mon.last_result);
            end
            mismatches++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        scan_byte(in_mon.character, in_mon.final_char);
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == FIRST_LINE_ADDR)
        first_line_reg = cfg_pwdata[LINE_BITS-1:0];
    end
    mismatch_count <= mismatches;
    words_pending  <= token_words.size();
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Drives the tokenizer with short directed sources and then random source
// texts built mostly from well-formed tokens, under several first-line
// settings, with random idling on both channels and one long output stall.
// The checker beside the block predicts and compares every token word.
// ---------------------------------------------------------------------------
module testbench;
  import btok_pkg::*;

  localparam int unsigned CLK_HALF         = 10;
  localparam int unsigned LIMIT_NS         = 10_000_000;
  localparam int unsigned SETTLE_CYCLES    = 8;
  localparam int unsigned LONG_HOLD_CYCLES = 400;
  localparam int unsigned PHASES           = 6;
  localparam int unsigned PHASE_ITEMS      = 60;
  localparam logic [CFG_ADDR_BITS-1:0] FIRST_LINE_ADDR = {REG_FIRST_LINE, 2'b00};
  localparam logic [CFG_ADDR_BITS-1:0] UNMAPPED_ADDR   = {1'b1, 2'b00};

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_psel;
  logic                     cfg_penable;
  logic                     cfg_pwrite;
  logic [CFG_ADDR_BITS-1:0] cfg_paddr;
  logic [CFG_DATA_BITS-1:0] cfg_pwdata;
  logic [CFG_DATA_BITS-1:0] cfg_prdata;
  logic                     cfg_pready;
  int unsigned              mismatch_count;
  int unsigned              words_pending;

  logic [CHAR_BITS-1:0]     source_text[$];
  int unsigned              items_sent    = 0;
  int unsigned              gap_pct       = 15;
  bit                       idle_on       = 1'b1;
  bit                       long_hold_go  = 1'b0;

  btok_in_if  in_chan ();
  btok_out_if out_chan ();

  b_language_tokenizer_unit uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  tokenizer_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_chan),
    .out_mon        (out_chan),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_pready     (cfg_pready),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .mismatch_count (mismatch_count),
    .words_pending  (words_pending)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  initial begin
    #(LIMIT_NS);
    $display("FAILURE");
    $finish;
  end

  // Output side: random ready bursts, one long hold on request
  initial begin
    out_chan.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold_go) begin
        long_hold_go = 1'b0;
        out_chan.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 2) == 0) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_chan.ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
  end

  // Setup cycle, access cycle until pready, then back to idle
  task automatic apb_write(input logic [CFG_ADDR_BITS-1:0] addr,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one character, maybe after a gap, and hold until accepted
  task automatic send_byte(input logic [CHAR_BITS-1:0] c, input logic fin);
    if (idle_on && $urandom_range(0, 99) < gap_pct) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.character  <= c;
    in_chan.final_char <= fin;
    do @(posedge clk); while (!in_chan.ready);
    items_sent++;
  endtask

  task automatic send_text(input bit closed);
    for (int i = 0; i < source_text.size(); i++)
      send_byte(source_text[i], closed && (i == source_text.size() - 1));
    source_text.delete();
  endtask

  // Stop offering, wait for every word, then let the block settle
  task automatic drain();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Append one character to the source under construction
  task automatic append_char(input logic [CHAR_BITS-1:0] c);
    source_text = {source_text, c};
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) append_char(s[i]);
  endtask

  function automatic logic [CHAR_BITS-1:0] rand_alnum(input bit letters_only);
    int unsigned k;
    k = $urandom_range(0, letters_only ? 51 : 61);
    if (k < 26) return CHAR_BITS'("a" + k);
    if (k < 52) return CHAR_BITS'("A" + k - 26);
    return CHAR_BITS'(CH_ZERO + k - 52);
  endfunction

  // Build one random source text, mostly tokens, some noise
  task automatic compose_source();
    int unsigned target;
    int unsigned pick;
    int unsigned n;
    string       kw;
    string       puncts;
    logic [CHAR_BITS-1:0] c;
    puncts = "(){}[],;+-*/";
    source_text.delete();
    target = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(3, 24);
    if ($urandom_range(0, 9) == 0) begin
      repeat (target) append_char(CHAR_BITS'($urandom_range(0, 255)));
      return;
    end
    while (source_text.size() < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        // keyword, sometimes cut short or lengthened
        case ($urandom_range(0, 3))
          0:       kw = "extrn";
          1:       kw = "return";
          2:       kw = "if";
          default: kw = "else";
        endcase
        n = ($urandom_range(0, 5) == 0) ? kw.len() - 1 : kw.len();
        for (int i = 0; i < n; i++) append_char(kw[i]);
        if ($urandom_range(0, 4) == 0) append_char(rand_alnum(1'b0));
      end else if (pick < 35) begin
        append_char(rand_alnum(1'b1));
        repeat ($urandom_range(0, 9)) append_char(rand_alnum(1'b0));
      end else if (pick < 50) begin
        repeat ($urandom_range(1, 12))
          append_char(CHAR_BITS'(CH_ZERO + $urandom_range(0, 9)));
      end else if (pick < 60) begin
        // string, newlines inside, closing quote usually present
        append_char(CH_QUOTE);
        repeat ($urandom_range(0, 6)) begin
          c = ($urandom_range(0, 3) == 0) ? CH_NEWLINE : CHAR_BITS'($urandom_range(0, 255));
          if (c == CH_QUOTE) c = CH_NEWLINE;
          append_char(c);
        end
        if ($urandom_range(0, 9) != 0) append_char(CH_QUOTE);
      end else if (pick < 78) begin
        append_char(puncts[$urandom_range(0, 11)]);
      end else if (pick < 90) begin
        case ($urandom_range(0, 2))
          0:       append_char(8'h20);
          1:       append_char(CH_NEWLINE);
          default: append_char(8'h09);
        endcase
      end else begin
        append_char(CHAR_BITS'($urandom_range(0, 255)));
      end
      if (pick < 60 && $urandom_range(0, 99) < 55)
        append_char(($urandom_range(0, 1) == 0) ? 8'h20 : CH_NEWLINE);
    end
  endtask

  initial begin
    int unsigned          quota;
    logic [LINE_BITS-1:0] line_seed;
    logic [CFG_DATA_BITS-1:0] wdata;
    rst_n              <= 1'b0;
    in_chan.valid      <= 1'b0;
    in_chan.character  <= '0;
    in_chan.final_char <= 1'b0;
    cfg_psel           <= 1'b0;
    cfg_penable        <= 1'b0;
    cfg_pwrite         <= 1'b0;
    cfg_paddr          <= '0;
    cfg_pwdata         <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // New first line only applies after the next final character
    apb_write(FIRST_LINE_ADDR, '0);

    // Keyword, space, number cut by a newline, ignored byte, punctuation last
    push_text("else 42\n");
    append_char(8'hFF);
    push_text("(");
    send_text(1'b1);
    // String holding a newline, then a name left open at the last byte
    push_text("\"a\n\"x");
    send_text(1'b1);
    // Ignored byte alone as the last byte
    append_char(8'h00);
    send_text(1'b1);
    // Number left open at the last byte
    push_text("9");
    send_text(1'b1);
    push_text("return)");
    send_text(1'b1);
    drain();

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       line_seed = LINE_MAX;
        1:       line_seed = '0;
        3:       line_seed = LINE_MAX - 1'b1;
        5:       line_seed = FIRST_LINE_RESET;
        default: line_seed = LINE_BITS'($urandom);
      endcase
      wdata = $urandom;
      wdata[LINE_BITS-1:0] = line_seed;
      apb_write(FIRST_LINE_ADDR, wdata);
      if (phase == 2) apb_write(UNMAPPED_ADDR, $urandom);
      if (phase == 1) long_hold_go = 1'b1;
      if (phase == PHASES - 1) idle_on = 1'b0;
      quota = items_sent + PHASE_ITEMS;
      while (items_sent < quota) begin
        compose_source();
        gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 20;
        send_text(1'b1);
      end
      // Leave a source open across the next register write
      if (phase == 3) begin
        compose_source();
        send_text(1'b0);
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && words_pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
